/* sv/bracket_aware_token_splitter_defines.svh */
// assertion macros for the bracket aware token splitter
`ifndef BRACKET_AWARE_TOKEN_SPLITTER_DEFINES_SVH
`define BRACKET_AWARE_TOKEN_SPLITTER_DEFINES_SVH

// property checked on every rising clock edge out of reset
`define BATS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication checked out of reset
`define BATS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bats_pkg.sv */
// shared types and constants of the bracket aware token splitter
package bats_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned CFG_IW     = 3;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;

    typedef enum logic [CFG_IW-1:0] {
        CFG_SPLITTER_CHARS  = 3'd0,
        CFG_SPLITTER_KEEP   = 3'd1,
        CFG_SINGLE_CHARS    = 3'd2,
        CFG_BLOCK_PAIRS     = 3'd3,
        CFG_SEPARATED_PAIRS = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       token_end;
        logic       list_end;
    } t_result;

endpackage

/* sv/bracket_aware_token_splitter.sv */
// bracket aware token splitter: classifies each byte and queues token bytes and end marks
//
//  channel | direction | handshake              | payload
//  s       | in        | i_s_tvalid/o_s_tready  | tdata ch, tuser kind
//  m       | out       | o_m_tvalid/i_m_tready  | tdata out_byte, tlast token_end,
//          |           |                        | tuser {list_end, has_byte}
//  cfg     | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  one request is classified and its state updated in the cycle it is accepted
//  its zero to two results go into a four-entry result queue, drained while i_m_tready is high at one per cycle
//  a new request is taken every cycle while the queue holds two or fewer results
//  requests that give two results drain, while i_m_tready is high, at one result per cycle at the output
//  synchronous active-low reset clears state, configuration and the queue
module bracket_aware_token_splitter #(
    parameter int unsigned MAX_NEST    = 255,
    parameter int unsigned CLASS_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // ch
    input  logic        i_s_tuser,   // kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser,   // has_byte, list_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [bats_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int unsigned DW         = $clog2(MAX_NEST + 1);
    localparam int unsigned PAIR_SLOTS = (CLASS_SLOTS < 4) ? CLASS_SLOTS : 4;
    localparam int unsigned CW         = $clog2(bats_pkg::FIFO_DEPTH + 1);
    localparam int unsigned AW         = bats_pkg::FIFO_AW;

    logic [63:0] r_split;
    logic [7:0]  r_keep;
    logic [63:0] r_single;
    logic [63:0] r_block;
    logic [63:0] r_sep;

    logic [DW-1:0] r_depth, n_depth;
    logic [7:0]    r_open, n_open;
    logic [7:0]    r_close, n_close;
    logic          r_sep_flag, n_sep_flag;
    logic          r_tok, n_tok;

    bats_pkg::t_result r_fifo [bats_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count, n_count;

    logic          in_acc, out_acc;
    logic [7:0]    c;
    logic          sp_hit, si_hit, bp_hit, sep_hit;
    logic [2:0]    sp_idx;
    logic [7:0]    bp_close, sep_close;
    logic          hb, hb_fresh;
    logic [DW-1:0] dec_depth;
    logic [1:0]    push_n;
    bats_pkg::t_result res0, res1;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_count <= CW'(bats_pkg::FIFO_DEPTH - 2));
    assign in_acc      = i_s_tvalid & o_s_tready;
    assign o_m_tvalid  = (r_count != '0);
    assign out_acc     = o_m_tvalid & i_m_tready;
    assign c           = i_s_tdata;

    assign o_m_tdata    = r_fifo[r_rd].out_byte;
    assign o_m_tlast    = r_fifo[r_rd].token_end;
    assign o_m_tuser[0] = r_fifo[r_rd].has_byte;
    assign o_m_tuser[1] = r_fifo[r_rd].list_end;

    // slot matching, lowest slot wins
    always_comb begin
        sp_hit    = 1'b0;
        sp_idx    = '0;
        si_hit    = 1'b0;
        bp_hit    = 1'b0;
        bp_close  = '0;
        sep_hit   = 1'b0;
        sep_close = '0;
        for (int k = CLASS_SLOTS - 1; k >= 0; k--) begin
            if (c != 8'h00 && r_split[8*k +: 8] == c) begin
                sp_hit = 1'b1;
                sp_idx = 3'(k);
            end
            if (c != 8'h00 && r_single[8*k +: 8] == c) begin
                si_hit = 1'b1;
            end
        end
        for (int k = PAIR_SLOTS - 1; k >= 0; k--) begin
            if (c != 8'h00 && r_block[16*k +: 8] == c) begin
                bp_hit   = 1'b1;
                bp_close = r_block[16*k+8 +: 8];
            end
            if (c != 8'h00 && r_sep[16*k +: 8] == c) begin
                sep_hit   = 1'b1;
                sep_close = r_sep[16*k+8 +: 8];
            end
        end
    end

    // next state and results of one request
    always_comb begin
        hb         = r_tok | (c != bats_pkg::SPACE_CHAR);
        hb_fresh   = (c != bats_pkg::SPACE_CHAR);
        dec_depth  = r_depth;
        n_depth    = r_depth;
        n_open     = r_open;
        n_close    = r_close;
        n_sep_flag = r_sep_flag;
        n_tok      = r_tok;
        push_n     = 2'd1;
        res0       = '{out_byte: (hb ? c : 8'h00), has_byte: hb, token_end: 1'b0,
                       list_end: 1'b0};
        res1       = '{out_byte: (hb_fresh ? c : 8'h00), has_byte: hb_fresh,
                       token_end: 1'b0, list_end: 1'b0};
        if (i_s_tuser) begin
            res0       = '{out_byte: 8'h00, has_byte: 1'b0, token_end: r_tok, list_end: 1'b1};
            n_depth    = '0;
            n_open     = '0;
            n_close    = '0;
            n_sep_flag = 1'b0;
            n_tok      = 1'b0;
        end else if (r_depth != '0) begin
            if (c == r_close) begin
                dec_depth = r_depth - 1'b1;
            end else if (c == r_open && r_depth < DW'(MAX_NEST)) begin
                dec_depth = r_depth + 1'b1;
            end
            n_depth = dec_depth;
            n_tok   = 1'b1;
            if (dec_depth == '0) begin
                if (r_sep_flag || sp_hit) begin
                    res0.token_end = 1'b1;
                    n_tok          = 1'b0;
                end
                n_sep_flag = 1'b0;
                n_close    = '0;
            end
        end else if (sp_hit) begin
            n_tok = 1'b0;
            if (r_keep[sp_idx]) begin
                res0.token_end = 1'b1;
            end else if (r_tok) begin
                res0 = '{out_byte: 8'h00, has_byte: 1'b0, token_end: 1'b1, list_end: 1'b0};
            end else begin
                push_n = 2'd0;
            end
        end else if (si_hit) begin
            n_tok           = 1'b0;
            res1.token_end  = 1'b1;
            if (r_tok) begin
                res0   = '{out_byte: 8'h00, has_byte: 1'b0, token_end: 1'b1, list_end: 1'b0};
                push_n = 2'd2;
            end else begin
                res0 = res1;
            end
        end else if (bp_hit) begin
            n_open     = c;
            n_close    = bp_close;
            n_depth    = DW'(1);
            n_sep_flag = 1'b0;
            n_tok      = 1'b1;
        end else if (sep_hit) begin
            n_open     = c;
            n_close    = sep_close;
            n_depth    = DW'(1);
            n_sep_flag = 1'b1;
            n_tok      = 1'b1;
            if (r_tok) begin
                res0   = '{out_byte: 8'h00, has_byte: 1'b0, token_end: 1'b1, list_end: 1'b0};
                push_n = 2'd2;
            end else begin
                res0 = res1;
            end
        end else begin
            n_tok = 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = n_count + CW'(push_n);
        end
        if (out_acc) begin
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split    <= '0;
            r_keep     <= '0;
            r_single   <= '0;
            r_block    <= '0;
            r_sep      <= '0;
            r_depth    <= '0;
            r_open     <= '0;
            r_close    <= '0;
            r_sep_flag <= 1'b0;
            r_tok      <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bats_pkg::CFG_SPLITTER_CHARS:  r_split  <= i_cfg_data;
                    bats_pkg::CFG_SPLITTER_KEEP:   r_keep   <= i_cfg_data[7:0];
                    bats_pkg::CFG_SINGLE_CHARS:    r_single <= i_cfg_data;
                    bats_pkg::CFG_BLOCK_PAIRS:     r_block  <= i_cfg_data;
                    bats_pkg::CFG_SEPARATED_PAIRS: r_sep    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_depth    <= n_depth;
                r_open     <= n_open;
                r_close    <= n_close;
                r_sep_flag <= n_sep_flag;
                r_tok      <= n_tok;
                r_wr       <= r_wr + AW'(push_n);
            end
            if (out_acc) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // result queue payload
    always_ff @(posedge i_clk) begin
        if (in_acc && push_n != 2'd0) begin
            r_fifo[r_wr] <= res0;
        end
        if (in_acc && push_n == 2'd2) begin
            r_fifo[r_wr + 1'b1] <= res1;
        end
    end

`include "bracket_aware_token_splitter_defines.svh"

    `BATS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(bats_pkg::FIFO_DEPTH), "result queue overflow")
    `BATS_ASSERT(a_depth_bound, i_clk, i_rst_n, r_depth <= DW'(MAX_NEST), "nest depth above limit")
    `BATS_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, in_acc && i_s_tuser, r_depth == '0 && !r_tok && !r_sep_flag, "end of text left state behind")
    `BATS_ASSERT_NEXT(a_drain_moves, i_clk, i_rst_n, out_acc && !in_acc, r_count == $past(r_count) - 1'b1, "drain without count change")

endmodule
